/* src/inv_ncdf_pkg.sv */
// Shared constants, fixed-point coefficients and item types for the
// inverse normal CDF core. No dependencies.
`default_nettype none

package inv_ncdf_pkg;

  localparam int PROB_BITS_DEF     = 32;
  localparam int OUT_FRAC_BITS_DEF = 24;
  localparam int QUEUE_DEPTH_DEF   = 4;

  // Internal fraction bits and mantissa width (m in [1,2), Q1.30)
  localparam int IFB = 28;
  localparam int EW  = 6;
  localparam int MW  = 31;

  localparam logic [31:0] LN2_Q30 = 32'h2C5C85FE;
  localparam logic [31:0] ONE_Q28 = 32'h1000_0000;

  // Rational approximation coefficients, rounded to Q.28
  localparam logic [31:0] C0_Q28 = 32'(((64'd2515517 << IFB) + 64'd500000) / 64'd1000000);
  localparam logic [31:0] C1_Q28 = 32'(((64'd802853 << IFB) + 64'd500000) / 64'd1000000);
  localparam logic [31:0] C2_Q28 = 32'(((64'd10328 << IFB) + 64'd500000) / 64'd1000000);
  localparam logic [31:0] D1_Q28 = 32'(((64'd1432788 << IFB) + 64'd500000) / 64'd1000000);
  localparam logic [31:0] D2_Q28 = 32'(((64'd189269 << IFB) + 64'd500000) / 64'd1000000);
  localparam logic [31:0] D3_Q28 = 32'(((64'd1308 << IFB) + 64'd500000) / 64'd1000000);

  typedef struct packed {
    logic zero;
    logic lower;
  } flags_t;

  typedef struct packed {
    flags_t          flags;
    logic [EW-1:0]   e;
    logic [MW-1:0]   m;
  } item_t;

endpackage

`default_nettype wire

/* src/inv_ncdf_front.sv */
// Front end: accepts probabilities, folds to the tail, normalizes.
// Depends on inv_ncdf_pkg.
`default_nettype none

module inv_ncdf_front #(
  parameter int PROB_BITS = inv_ncdf_pkg::PROB_BITS_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         s_tvalid,
  output logic                        s_tready,
  input  wire  [31:0]                 s_tdata,
  output logic                        out_valid,
  input  wire                         out_ready,
  output inv_ncdf_pkg::item_t         out_item
);

  localparam int EW = inv_ncdf_pkg::EW;
  localparam int MW = inv_ncdf_pkg::MW;

  logic en;
  logic [PROB_BITS-1:0] p_in;
  logic [PROB_BITS-1:0] q_in;
  logic                 lower_in;

  logic                 v1, v2, v3;
  inv_ncdf_pkg::flags_t f1, f2;
  logic [PROB_BITS-1:0] q1, q2;
  logic [EW-1:0]        e_c, e2;
  logic [PROB_BITS+MW-2:0] wide;
  inv_ncdf_pkg::item_t  item3;

  assign en       = !(v3 && !out_ready);
  assign s_tready = en;

  assign p_in     = PROB_BITS'(s_tdata);
  assign lower_in = !p_in[PROB_BITS-1];
  assign q_in     = lower_in ? p_in : (PROB_BITS'(0) - p_in);

  // leading one position
  always_comb begin
    e_c = '0;
    for (int i = 0; i < PROB_BITS; i++) begin
      if (q1[i]) e_c = EW'(i);
    end
  end

  assign wide = {q2, (MW-1)'(0)} >> e2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1.zero     <= (p_in == '0);
      f1.lower    <= lower_in;
      q1          <= q_in;
      f2          <= f1;
      q2          <= q1;
      e2          <= e_c;
      item3.flags <= f2;
      item3.e     <= e2;
      item3.m     <= wide[MW-1:0];
    end
  end

  assign out_valid = v3;
  assign out_item  = item3;

endmodule

`default_nettype wire

/* src/inv_ncdf_queue.sv */
// Small register FIFO between front and back end.
// Depends on inv_ncdf_pkg.
`default_nettype none

module inv_ncdf_queue #(
  parameter int DEPTH = inv_ncdf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push_valid,
  output logic                 push_ready,
  input  inv_ncdf_pkg::item_t  push_item,
  output logic                 pop_valid,
  input  wire                  pop,
  output inv_ncdf_pkg::item_t  pop_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  inv_ncdf_pkg::item_t mem [0:DEPTH-1];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic push_fire, pop_fire;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop && pop_valid;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + AW'(1);
      if (pop_fire)  rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + AW'(1);
      if (push_fire && !pop_fire)      count <= count + CW'(1);
      else if (pop_fire && !push_fire) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) mem[wr_ptr] <= push_item;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count overflow");

  a_empty_pass: assert property (@(posedge clk) disable iff (rst)
    (push_fire && count == '0) |=> (pop_valid && pop_item == $past(push_item)))
    else $error("item pushed to empty queue not visible");
`endif

endmodule

`default_nettype wire

/* src/inv_ncdf_back.sv */
// Back end: log2 by squaring, -2ln scaling, sqrt, rational correction,
// divide and output rounding, all pipelined. Depends on inv_ncdf_pkg.
`default_nettype none

module inv_ncdf_back #(
  parameter int PROB_BITS     = inv_ncdf_pkg::PROB_BITS_DEF,
  parameter int OUT_FRAC_BITS = inv_ncdf_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  inv_ncdf_pkg::item_t  in_item,
  output logic                 o_valid,
  input  wire                  o_ready,
  output logic [31:0]          o_quantile,
  output logic                 o_invalid
);

  localparam int IFB = inv_ncdf_pkg::IFB;
  localparam int EW  = inv_ncdf_pkg::EW;
  localparam int MW  = inv_ncdf_pkg::MW;
  localparam int LS  = IFB;
  localparam int NW  = $clog2(PROB_BITS + 1) + IFB;
  localparam int NLO = 17;
  localparam int PW  = NW + 30;
  localparam int UW  = PW - 29;
  localparam int SW  = UW + IFB;
  localparam int TW  = (SW + 1) / 2;
  localparam int XW  = 2 * TW;
  localparam int RW  = TW + 3;
  localparam int QW  = IFB + 2;
  localparam int DRW = 34;
  localparam int S   = OUT_FRAC_BITS - IFB;
  localparam int RS  = (S < 0) ? -S : 1;

  logic en;
  assign en       = !(o_valid && !o_ready);
  assign in_ready = en;

  // ---------------- log2 by repeated squaring
  logic                 lg_v  [0:LS];
  inv_ncdf_pkg::flags_t lg_f  [0:LS];
  logic [EW-1:0]        lg_e  [0:LS];
  logic [MW-1:0]        lg_m  [0:LS];
  logic [LS-1:0]        lg_fr [0:LS];

  always_ff @(posedge clk) begin
    if (rst) lg_v[0] <= 1'b0;
    else if (en) lg_v[0] <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      lg_f[0]  <= in_item.flags;
      lg_e[0]  <= in_item.e;
      lg_m[0]  <= in_item.m;
      lg_fr[0] <= '0;
    end
  end

  for (genvar i = 0; i < LS; i++) begin : g_log
    logic [2*MW-1:0] sq;
    logic [MW:0]     mm;
    assign sq = lg_m[i] * lg_m[i];
    assign mm = sq[2*MW-1:MW-1];
    always_ff @(posedge clk) begin
      if (rst) lg_v[i+1] <= 1'b0;
      else if (en) lg_v[i+1] <= lg_v[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        lg_f[i+1]  <= lg_f[i];
        lg_e[i+1]  <= lg_e[i];
        lg_m[i+1]  <= mm[MW] ? mm[MW:1] : mm[MW-1:0];
        lg_fr[i+1] <= {lg_fr[i][LS-2:0], mm[MW]};
      end
    end
  end

  // ---------------- n = PROB_BITS - log2(q), then u = n * 2ln2
  logic                 n_v, ma_v;
  inv_ncdf_pkg::flags_t n_f, ma_f;
  logic [NW-1:0]        n_r;
  logic [NLO+31:0]      p_lo;
  logic [NW-NLO+31:0]   p_hi;
  logic [PW-1:0]        u_sum;

  assign u_sum = (PW'(p_hi) << NLO) + PW'(p_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      n_v  <= 1'b0;
      ma_v <= 1'b0;
    end else if (en) begin
      n_v  <= lg_v[LS];
      ma_v <= n_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      n_f  <= lg_f[LS];
      n_r  <= (NW'(PROB_BITS) << IFB) - NW'({lg_e[LS], lg_fr[LS]});
      ma_f <= n_f;
      p_lo <= n_r[NLO-1:0] * inv_ncdf_pkg::LN2_Q30;
      p_hi <= n_r[NW-1:NLO] * inv_ncdf_pkg::LN2_Q30;
    end
  end

  // ---------------- sqrt, one root bit per stage; index 0 holds u
  logic                 sr_v   [0:TW];
  inv_ncdf_pkg::flags_t sr_f   [0:TW];
  logic [XW-1:0]        sr_x   [0:TW];
  logic [RW-1:0]        sr_rem [0:TW];
  logic [TW-1:0]        sr_rt  [0:TW];

  always_ff @(posedge clk) begin
    if (rst) sr_v[0] <= 1'b0;
    else if (en) sr_v[0] <= ma_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sr_f[0]   <= ma_f;
      sr_x[0]   <= XW'({u_sum[PW-1:29], IFB'(0)});
      sr_rem[0] <= '0;
      sr_rt[0]  <= '0;
    end
  end

  for (genvar k = 0; k < TW; k++) begin : g_sqrt
    logic [RW-1:0] rs, trial;
    logic          ge;
    assign rs    = {sr_rem[k][RW-3:0], sr_x[k][XW-1:XW-2]};
    assign trial = RW'({sr_rt[k], 2'b01});
    assign ge    = (rs >= trial);
    always_ff @(posedge clk) begin
      if (rst) sr_v[k+1] <= 1'b0;
      else if (en) sr_v[k+1] <= sr_v[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sr_f[k+1]   <= sr_f[k];
        sr_x[k+1]   <= sr_x[k] << 2;
        sr_rem[k+1] <= ge ? (rs - trial) : rs;
        sr_rt[k+1]  <= {sr_rt[k][TW-2:0], ge};
      end
    end
  end

  // ---------------- Horner polynomials
  logic                 h1_v, h2_v;
  inv_ncdf_pkg::flags_t h1_f, h2_f;
  logic [TW-1:0]        h1_t, h2_t;
  logic [29:0]          h1_num, h1_den;
  logic [31:0]          h2_num, h2_den;
  logic [32+TW-1:0]     p1n, p1d, p3d;
  logic [30+TW-1:0]     p2n, p2d;

  assign p1n = inv_ncdf_pkg::C2_Q28 * sr_rt[TW];
  assign p1d = inv_ncdf_pkg::D3_Q28 * sr_rt[TW];
  assign p2n = h1_num * h1_t;
  assign p2d = h1_den * h1_t;
  assign p3d = h2_den * h2_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      h1_v <= 1'b0;
      h2_v <= 1'b0;
    end else if (en) begin
      h1_v <= sr_v[TW];
      h2_v <= h1_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      h1_f   <= sr_f[TW];
      h1_t   <= sr_rt[TW];
      h1_num <= 30'(p1n >> IFB) + 30'(inv_ncdf_pkg::C1_Q28);
      h1_den <= 30'(p1d >> IFB) + 30'(inv_ncdf_pkg::D2_Q28);
      h2_f   <= h1_f;
      h2_t   <= h1_t;
      h2_num <= 32'(p2n >> IFB) + inv_ncdf_pkg::C0_Q28;
      h2_den <= 32'(p2d >> IFB) + inv_ncdf_pkg::D1_Q28;
    end
  end

  // ---------------- restoring divide, one quotient bit per stage
  logic                 dv_v   [0:QW];
  inv_ncdf_pkg::flags_t dv_f   [0:QW];
  logic [TW-1:0]        dv_t   [0:QW];
  logic [32:0]          dv_den [0:QW];
  logic [DRW-1:0]       dv_r   [0:QW];
  logic [QW-1:0]        dv_dl  [0:QW];
  logic [QW-1:0]        dv_q   [0:QW];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= h2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dv_f[0]   <= h2_f;
      dv_t[0]   <= h2_t;
      dv_den[0] <= 33'(p3d >> IFB) + 33'(inv_ncdf_pkg::ONE_Q28);
      dv_r[0]   <= DRW'(h2_num >> 2);
      dv_dl[0]  <= {h2_num[1:0], IFB'(0)};
      dv_q[0]   <= '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [DRW-1:0] rs;
    logic           ge;
    assign rs = {dv_r[j][DRW-2:0], dv_dl[j][QW-1]};
    assign ge = (rs >= DRW'(dv_den[j]));
    always_ff @(posedge clk) begin
      if (rst) dv_v[j+1] <= 1'b0;
      else if (en) dv_v[j+1] <= dv_v[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_f[j+1]   <= dv_f[j];
        dv_t[j+1]   <= dv_t[j];
        dv_den[j+1] <= dv_den[j];
        dv_r[j+1]   <= ge ? (rs - DRW'(dv_den[j])) : rs;
        dv_dl[j+1]  <= dv_dl[j] << 1;
        dv_q[j+1]   <= {dv_q[j][QW-2:0], ge};
      end
    end
  end

  // ---------------- difference and sign
  logic                 f_v, f_zero, f_neg;
  logic [31:0]          f_mag;
  logic [31:0]          tt, rr;

  assign tt = 32'(dv_t[QW]);
  assign rr = 32'(dv_q[QW]);

  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else if (en) f_v <= dv_v[QW];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f_zero <= dv_f[QW].zero;
      f_mag  <= (tt >= rr) ? (tt - rr) : (rr - tt);
      f_neg  <= (tt < rr) ^ dv_f[QW].lower;
    end
  end

  // ---------------- rescale, saturate, output register
  logic [63:0] scaled;
  logic [31:0] res;

  if (S >= 0) begin : g_left
    assign scaled = 64'(f_mag) << S;
  end else begin : g_right
    assign scaled = (64'(f_mag) + (64'd1 << (RS - 1))) >> RS;
  end

  always_comb begin
    if (f_zero) res = '0;
    else if (f_neg) res = (scaled > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - scaled[31:0]);
    else res = (scaled > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : scaled[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) o_valid <= 1'b0;
    else if (en) o_valid <= f_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      o_quantile <= res;
      o_invalid  <= f_zero;
    end
  end

`ifndef NO_ASSERTIONS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_invalid) |-> (o_quantile == '0))
    else $error("invalid item with nonzero quantile");
`endif

endmodule

`default_nettype wire

/* src/inverse_normal_cdf_core.sv */
// Pipeline at default parameters: 3 front stages, the first loaded by the accepting
// edge, 1 queue stage, and a back end of IFB + sqrt width + 39 stages.
// Throughput: one item per cycle while m_tready back-pressure does not stall the
// pipelines, fully pipelined; the 31x31 squaring chain, the bit-per-stage sqrt
// and the bit-per-stage divider each take one stage per bit.
// Reset: rst is synchronous, active high; clears all valid bits and queue pointers.
// Top level of the inverse normal CDF core. Depends on inv_ncdf_pkg,
// inv_ncdf_front, inv_ncdf_queue and inv_ncdf_back.
`default_nettype none

module inverse_normal_cdf_core #(
  parameter int PROB_BITS     = inv_ncdf_pkg::PROB_BITS_DEF,
  parameter int OUT_FRAC_BITS = inv_ncdf_pkg::OUT_FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH   = inv_ncdf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,   // [31:0] prob
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // [31:0] quantile
  output logic        m_tuser    // [0] invalid
);

  // front end -> queue
  logic                f_valid, f_ready;
  inv_ncdf_pkg::item_t f_item;

  // queue -> back end
  logic                b_valid, b_ready;
  inv_ncdf_pkg::item_t b_item;

  // Front: masks to PROB_BITS, folds to the tail q, finds the leading one
  // and normalizes q to a Q1.30 mantissa.
  inv_ncdf_front #(
    .PROB_BITS (PROB_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  // Short queue decouples the two pipelines' stall domains.
  inv_ncdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop        (b_ready),
    .pop_item   (b_item)
  );

  // Back: log2, -2ln, sqrt, rational correction, divide, round and
  // saturate; the last stage is the output register.
  inv_ncdf_back #(
    .PROB_BITS     (PROB_BITS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (b_valid),
    .in_ready   (b_ready),
    .in_item    (b_item),
    .o_valid    (m_tvalid),
    .o_ready    (m_tready),
    .o_quantile (m_tdata),
    .o_invalid  (m_tuser)
  );

endmodule

`default_nettype wire
